/* hw/rtl/orb_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// orb_pkg
// request codes, state encoding and fixed field widths of the overwrite ring
// ----------------------------------------------------------------------------
package orb_pkg;

  localparam int unsigned REQ_W   = 2;
  localparam int unsigned CAP_W   = 5;
  localparam int unsigned IDX_W   = 4;
  localparam int unsigned COUNT_W = 5;

  typedef enum logic [REQ_W-1:0] {
    REQ_PUSH     = 2'd0,
    REQ_POP      = 2'd1,
    REQ_PEEK_OLD = 2'd2,
    REQ_PEEK_NEW = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_READ = 2'b10
  } state_t;

endpackage : orb_pkg
`default_nettype wire

/* hw/rtl/orb_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// orb_ram
// single-port synchronous ram, one access per cycle, registered read data
// ----------------------------------------------------------------------------
module orb_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     en,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule : orb_ram
`default_nettype wire

/* hw/rtl/overwrite_ring_buffer_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// overwrite_ring_buffer_core
// history ring of entry words that drops the oldest entry when a push finds it
// full; supports pop of the oldest and peeks from either end
// ----------------------------------------------------------------------------
// For each request, the accept cycle updates the pointers and fill and sends
// the one slot access (write for a push, read otherwise) to the single-port
// slot ram; the next cycle the registered read data completes the result. A
// new request is accepted only after the last has left the read state. Every
// request accepted without a capacity write in that cycle gives exactly one
// result. A write to the capacity register empties the ring; the user must
// write it only while no request is in flight; the block does not enforce it.
// Slot contents need no clearing: only entries within the count are output.
module overwrite_ring_buffer_core #(
  parameter int unsigned DEPTH       = 16,
  parameter int unsigned ENTRY_WIDTH = 32
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        cfg_wr_en,
  input  wire logic [orb_pkg::CAP_W-1:0]   cfg_wr_data,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [orb_pkg::REQ_W-1:0]   in_req_type,
  input  wire logic [ENTRY_WIDTH-1:0]      in_entry_value,
  input  wire logic [orb_pkg::IDX_W-1:0]   in_index,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic                             out_ok,
  output logic      [ENTRY_WIDTH-1:0]      out_data,
  output logic                             out_overwrote,
  output logic      [orb_pkg::COUNT_W-1:0] out_count,
  output logic                             out_full_res
);

  import orb_pkg::*;

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned CW_W  = (CNT_W > CAP_W) ? CNT_W : CAP_W;
  localparam int unsigned AW_I  = (CNT_W > IDX_W) ? CNT_W : IDX_W;
  localparam int unsigned AW    = AW_I + 1;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cap_r, cap_nxt;
  logic [CNT_W-1:0] fill_r, fill_nxt;
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             pend_rd_r, pend_rd_nxt;

  logic                   out_ok_r;
  logic [ENTRY_WIDTH-1:0] out_data_r;
  logic                   out_overwrote_r;
  logic [COUNT_W-1:0]     out_count_r;
  logic                   out_full_res_r;

  req_t             req;
  logic             accept;
  logic             full;
  logic             hit;
  logic             ok;
  logic             over;
  logic [CW_W-1:0]  cfg_ext;
  logic [CNT_W-1:0] cap_eff;
  logic [CNT_W-1:0] wr_inc;
  logic [CNT_W-1:0] rd_inc;
  logic [AW-1:0]    pos_old;
  logic [AW-1:0]    pos_new;
  logic [PTR_W-1:0] ram_addr;
  logic [ENTRY_WIDTH-1:0] ram_rdata;

  assign req      = req_t'(in_req_type);
  assign in_ready = (state_r == ST_IDLE) && (!out_valid_r || out_ready);
  assign accept   = in_valid && in_ready;
  assign full     = (fill_r == cap_r);
  assign hit      = AW_I'(in_index) < AW_I'(fill_r);

  // capacity out of range: zero acts as one, above the built depth as the depth
  assign cfg_ext = CW_W'(cfg_wr_data);
  always_comb begin
    if (cfg_ext == '0) begin
      cap_eff = CNT_W'(1);
    end else if (cfg_ext > CW_W'(DEPTH)) begin
      cap_eff = CNT_W'(DEPTH);
    end else begin
      cap_eff = CNT_W'(cfg_ext);
    end
  end

  assign wr_inc = (CNT_W'(wr_ptr_r) + CNT_W'(1) >= cap_r) ? '0 : CNT_W'(wr_ptr_r) + CNT_W'(1);
  assign rd_inc = (CNT_W'(rd_ptr_r) + CNT_W'(1) >= cap_r) ? '0 : CNT_W'(rd_ptr_r) + CNT_W'(1);

  // both sums stay below twice the capacity on a hit, so one subtract wraps them
  always_comb begin
    logic [AW-1:0] sum_old;
    logic [AW-1:0] sum_new;
    sum_old = AW'(rd_ptr_r) + AW'(in_index);
    sum_new = AW'(wr_ptr_r) + AW'(cap_r) - AW'(1) - AW'(in_index);
    pos_old = (sum_old >= AW'(cap_r)) ? sum_old - AW'(cap_r) : sum_old;
    pos_new = (sum_new >= AW'(cap_r)) ? sum_new - AW'(cap_r) : sum_new;
  end

  always_comb begin
    case (req)
      REQ_PUSH:     ram_addr = wr_ptr_r;
      REQ_POP:      ram_addr = rd_ptr_r;
      REQ_PEEK_OLD: ram_addr = pos_old[PTR_W-1:0];
      REQ_PEEK_NEW: ram_addr = pos_new[PTR_W-1:0];
      default:      ram_addr = wr_ptr_r;
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    cap_nxt       = cap_r;
    fill_nxt      = fill_r;
    wr_ptr_nxt    = wr_ptr_r;
    rd_ptr_nxt    = rd_ptr_r;
    out_valid_nxt = out_valid_r;
    pend_rd_nxt   = pend_rd_r;
    ok            = 1'b0;
    over          = 1'b0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (cfg_wr_en) begin
          cap_nxt    = cap_eff;
          fill_nxt   = '0;
          wr_ptr_nxt = '0;
          rd_ptr_nxt = '0;
        end else if (accept) begin
          case (req)
            REQ_PUSH: begin
              ok         = 1'b1;
              wr_ptr_nxt = PTR_W'(wr_inc);
              if (full) begin
                over       = 1'b1;
                rd_ptr_nxt = PTR_W'(rd_inc);
              end else begin
                fill_nxt = fill_r + CNT_W'(1);
              end
            end
            REQ_POP: begin
              if (fill_r != '0) begin
                ok         = 1'b1;
                rd_ptr_nxt = PTR_W'(rd_inc);
                fill_nxt   = fill_r - CNT_W'(1);
              end
            end
            REQ_PEEK_OLD, REQ_PEEK_NEW: begin
              ok = hit;
            end
            default: begin
              ok = 1'b0;
            end
          endcase
          pend_rd_nxt = ok && (req != REQ_PUSH);
          state_nxt   = ST_READ;
        end
      end
      ST_READ: begin
        out_valid_nxt = 1'b1;
        state_nxt     = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cap_r       <= CNT_W'(DEPTH);
      fill_r      <= '0;
      wr_ptr_r    <= '0;
      rd_ptr_r    <= '0;
      out_valid_r <= 1'b0;
      pend_rd_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cap_r       <= cap_nxt;
      fill_r      <= fill_nxt;
      wr_ptr_r    <= wr_ptr_nxt;
      rd_ptr_r    <= rd_ptr_nxt;
      out_valid_r <= out_valid_nxt;
      pend_rd_r   <= pend_rd_nxt;
    end
  end

  // status fields load at accept while the output is empty or being taken;
  // the data word loads as the read state ends, together with out_valid
  always_ff @(posedge clk) begin
    if (accept && !cfg_wr_en) begin
      out_ok_r        <= ok;
      out_overwrote_r <= over;
      out_count_r     <= COUNT_W'(fill_nxt);
      out_full_res_r  <= (fill_nxt == cap_r);
    end
    if (state_r == ST_READ) begin
      out_data_r <= pend_rd_r ? ram_rdata : '0;
    end
  end

  // a slot written at one accept is read no earlier than the next accept
  orb_ram #(
    .WIDTH(ENTRY_WIDTH),
    .DEPTH(DEPTH)
  ) u_slots (
    .clk  (clk),
    .en   (accept && !cfg_wr_en),
    .we   (req == REQ_PUSH),
    .addr (ram_addr),
    .wdata(in_entry_value),
    .rdata(ram_rdata)
  );

  assign out_valid     = out_valid_r;
  assign out_ok        = out_ok_r;
  assign out_data      = out_data_r;
  assign out_overwrote = out_overwrote_r;
  assign out_count     = out_count_r;
  assign out_full_res  = out_full_res_r;

endmodule : overwrite_ring_buffer_core
`default_nettype wire

/* sim/overwrite_ring_buffer_core_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// overwrite_ring_buffer_core_tb
// drives push, pop and peek requests into the history ring across a range of
// capacity settings, predicts every result in a ring scoreboard and checks
// each returned field, with random idling on both channels and one long
// output hold-off that backs the block up
// ----------------------------------------------------------------------------
module overwrite_ring_buffer_core_tb;
  import orb_pkg::*;

  localparam int unsigned DEPTH        = 16;
  localparam int unsigned PTR_W        = $clog2(DEPTH);
  localparam int unsigned ENTRY_W      = 32;
  localparam int unsigned PHASES       = 8;
  localparam int unsigned PHASE_ITEMS  = 66;
  localparam int unsigned HOLD_CYCLES  = 150;
  localparam int unsigned STALL_LIMIT  = 3000;
  localparam int unsigned REPORT_LIMIT = 200;

  typedef struct packed {
    logic               ok;
    logic [ENTRY_W-1:0] data;
    logic               overwrote;
    logic [COUNT_W-1:0] count;
    logic               full;
  } ring_result_t;

  // tracks the ring contents and the queue of results still owed by the block
  class ring_scoreboard;
    logic [ENTRY_W-1:0] slot_mem [DEPTH];
    int unsigned        head, tail, held, cap_reg;
    ring_result_t       owed_q[$];
    int unsigned        mismatches, requests, results, overwrites, misses;

    function void clear();
      head    = 0;
      tail    = 0;
      held    = 0;
      cap_reg = DEPTH;
    endfunction

    function void set_capacity(logic [CAP_W-1:0] value);
      cap_reg = 32'(value);
      head    = 0;
      tail    = 0;
      held    = 0;
    endfunction

    function int unsigned usable_slots();
      if (cap_reg == 0) return 1;
      if (cap_reg > DEPTH) return DEPTH;
      return cap_reg;
    endfunction

    function int unsigned advance(int unsigned ptr, int unsigned lim);
      return (ptr + 1 >= lim) ? 0 : ptr + 1;
    endfunction

    function void note_request(req_t kind, logic [ENTRY_W-1:0] word,
                               logic [IDX_W-1:0] offset);
      int unsigned  lim;
      int unsigned  off;
      ring_result_t res;
      lim = usable_slots();
      off = 32'(offset);
      if (held > lim) held = lim;
      if (head >= lim) head = 0;
      if (tail >= lim) tail = 0;
      res = '0;
      case (kind)
        REQ_PUSH: begin
          slot_mem[PTR_W'(head)] = word;
          if (held == lim) begin
            tail          = advance(tail, lim);
            res.overwrote = 1'b1;
            overwrites++;
          end else begin
            held++;
          end
          head   = advance(head, lim);
          res.ok = 1'b1;
        end
        REQ_POP: begin
          if (held != 0) begin
            res.data = slot_mem[PTR_W'(tail)];
            tail     = advance(tail, lim);
            held--;
            res.ok   = 1'b1;
          end
        end
        REQ_PEEK_OLD: begin
          if (off < held) begin
            res.data = slot_mem[PTR_W'((tail + off) % lim)];
            res.ok   = 1'b1;
          end
        end
        default: begin
          // newest entry sits one slot behind the head
          if (off < held) begin
            res.data = slot_mem[PTR_W'((head + 2 * lim - 1 - off) % lim)];
            res.ok   = 1'b1;
          end
        end
      endcase
      if (!res.ok) misses++;
      res.count = COUNT_W'(held);
      res.full  = (held == lim);
      owed_q.push_back(res);
      requests++;
    endfunction

    function void report(string what, logic [ENTRY_W-1:0] want, logic [ENTRY_W-1:0] got);
      mismatches++;
      if (mismatches <= REPORT_LIMIT)
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
      else if (mismatches == REPORT_LIMIT + 1)
        $display("%0t: further mismatches not shown", $time);
    endfunction

    function void check_result(ring_result_t got);
      ring_result_t want;
      results++;
      if (owed_q.size() == 0) begin
        report("unrequested result, data", '0, got.data);
        return;
      end
      want = owed_q.pop_front();
      if (got.ok !== want.ok)
        report("ok", ENTRY_W'(want.ok), ENTRY_W'(got.ok));
      if (got.data !== want.data)
        report("data", want.data, got.data);
      if (got.overwrote !== want.overwrote)
        report("overwrote", ENTRY_W'(want.overwrote), ENTRY_W'(got.overwrote));
      if (got.count !== want.count)
        report("count", ENTRY_W'(want.count), ENTRY_W'(got.count));
      if (got.full !== want.full)
        report("full_res", ENTRY_W'(want.full), ENTRY_W'(got.full));
    endfunction

    function int unsigned outstanding();
      return owed_q.size();
    endfunction
  endclass

  logic               clk;
  logic               rst_n;
  logic               cfg_wr_en;
  logic [CAP_W-1:0]   cfg_wr_data;
  logic               in_valid;
  logic               in_ready;
  logic [REQ_W-1:0]   in_req_type;
  logic [ENTRY_W-1:0] in_entry_value;
  logic [IDX_W-1:0]   in_index;
  logic               out_valid;
  logic               out_ready;
  logic               out_ok;
  logic [ENTRY_W-1:0] out_data;
  logic               out_overwrote;
  logic [COUNT_W-1:0] out_count;
  logic               out_full_res;

  ring_scoreboard ring_sb = new();
  int unsigned    send_gap_pct;
  int unsigned    recv_stall_pct;
  bit             hold_req;
  int unsigned    cap_settings;

  overwrite_ring_buffer_core #(
    .DEPTH       (DEPTH),
    .ENTRY_WIDTH (ENTRY_W)
  ) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_req_type    (in_req_type),
    .in_entry_value (in_entry_value),
    .in_index       (in_index),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_ok         (out_ok),
    .out_data       (out_data),
    .out_overwrote  (out_overwrote),
    .out_count      (out_count),
    .out_full_res   (out_full_res)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // requests are noted before results are checked, in case both land on one edge
  always @(posedge clk) begin
    ring_result_t got;
    if (rst_n && in_valid && in_ready)
      ring_sb.note_request(req_t'(in_req_type), in_entry_value, in_index);
    if (rst_n && out_valid && out_ready) begin
      got.ok        = out_ok;
      got.data      = out_data;
      got.overwrote = out_overwrote;
      got.count     = out_count;
      got.full      = out_full_res;
      ring_sb.check_result(got);
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
    $display("overwrite_ring_buffer_core_tb: errors");
    $finish;
  end

  // result side: random stalls, plus one long hold-off when asked
  initial begin : result_sink
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_item(input req_t kind, input logic [ENTRY_W-1:0] word,
                           input logic [IDX_W-1:0] offset);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_req_type    <= kind;
    in_entry_value <= word;
    in_index       <= offset;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic send_random(input bit filling);
    req_t               kind;
    logic [ENTRY_W-1:0] word;
    logic [IDX_W-1:0]   offset;
    int unsigned        roll;
    roll = $urandom_range(99);
    if (filling)
      kind = (roll < 50) ? REQ_PUSH : (roll < 62) ? REQ_POP :
             (roll < 81) ? REQ_PEEK_OLD : REQ_PEEK_NEW;
    else
      kind = (roll < 15) ? REQ_PUSH : (roll < 55) ? REQ_POP :
             (roll < 78) ? REQ_PEEK_OLD : REQ_PEEK_NEW;
    case ($urandom_range(9))
      0:       word = '0;
      1:       word = '1;
      default: word = $urandom;
    endcase
    if (ring_sb.held != 0 && $urandom_range(3) != 0)
      offset = IDX_W'($urandom_range(ring_sb.held - 1));
    else
      offset = IDX_W'($urandom_range(15));
    send_item(kind, word, offset);
  endtask

  // stop offering, let every owed result come back, then write the capacity
  task automatic write_capacity(input logic [CAP_W-1:0] value);
    in_valid <= 1'b0;
    while (ring_sb.outstanding() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    ring_sb.set_capacity(value);
    cap_settings++;
  endtask

  initial begin : stimulus
    logic [CAP_W-1:0] phase_cap [PHASES];
    rst_n          = 1'b0;
    cfg_wr_en      = 1'b0;
    cfg_wr_data    = '0;
    in_valid       = 1'b0;
    in_req_type    = REQ_PUSH;
    in_entry_value = '0;
    in_index       = '0;
    send_gap_pct   = 0;
    recv_stall_pct = 0;
    hold_req       = 1'b0;
    cap_settings   = 0;
    phase_cap      = '{5'd3, 5'd16, 5'd0, 5'd31, 5'd7, 5'd1, 5'd12, 5'd2};
    ring_sb.clear();
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // empty ring at the reset capacity, then edge values and peek misses
    send_item(REQ_POP,      32'h1234_5678, 4'd0);
    send_item(REQ_PEEK_OLD, '0,            4'd0);
    send_item(REQ_PEEK_NEW, '0,            4'd15);
    send_item(REQ_PUSH,     '0,            4'd0);
    send_item(REQ_PUSH,     '1,            4'd15);
    send_item(REQ_PEEK_OLD, '0,            4'd0);
    send_item(REQ_PEEK_NEW, '0,            4'd0);
    send_item(REQ_PEEK_OLD, '0,            4'd1);
    send_item(REQ_PEEK_NEW, '0,            4'd1);
    send_item(REQ_PEEK_OLD, '0,            4'd2);
    send_item(REQ_PEEK_NEW, '1,            4'd15);
    send_item(REQ_POP,      '0,            4'd0);
    send_item(REQ_POP,      '0,            4'd0);
    send_item(REQ_POP,      '0,            4'd0);

    // single slot: every push after the first drops the oldest
    write_capacity(5'd1);
    send_item(REQ_PUSH,     32'hA5A5_5A5A, 4'd0);
    send_item(REQ_PUSH,     32'h5A5A_A5A5, 4'd0);
    send_item(REQ_PEEK_OLD, '0,            4'd0);
    send_item(REQ_PEEK_NEW, '0,            4'd0);
    send_item(REQ_PEEK_NEW, '0,            4'd1);
    send_item(REQ_POP,      '0,            4'd0);
    send_item(REQ_POP,      '0,            4'd0);

    for (int p = 0; p < PHASES; p++) begin
      write_capacity(phase_cap[p]);
      case (p % 4)
        0:       begin send_gap_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_gap_pct = 64; recv_stall_pct = 0;  end
        2:       begin send_gap_pct = 0;  recv_stall_pct = 64; end
        default: begin send_gap_pct = 32; recv_stall_pct = 32; end
      endcase
      if (p == 4) hold_req = 1'b1;
      // alternate stretches that fill the ring and stretches that drain it
      for (int i = 0; i < PHASE_ITEMS; i++)
        send_random(((i / 20) % 2) == 0);
    end

    in_valid <= 1'b0;
    while (ring_sb.outstanding() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (ring_sb.outstanding() != 0)
      ring_sb.report("results still owed", '0, ring_sb.outstanding());

    $display("covered %0d requests and %0d results over %0d capacity settings",
             ring_sb.requests, ring_sb.results, cap_settings);
    $display("pushes that dropped the oldest: %0d, pops and peeks that missed: %0d",
             ring_sb.overwrites, ring_sb.misses);
    if (ring_sb.mismatches == 0)
      $display("overwrite_ring_buffer_core_tb: clean");
    else
      $display("overwrite_ring_buffer_core_tb: errors");
    $finish;
  end

endmodule

/* overwrite_ring_buffer_core.f */
hw/rtl/orb_pkg.sv
hw/rtl/orb_ram.sv
hw/rtl/overwrite_ring_buffer_core.sv
sim/overwrite_ring_buffer_core_tb.sv
